### rtl/vspc_pkg.sv
// vspc_pkg: shared types and character constants for the version string parser
// no dependencies; imported by every module of the block
package vspc_pkg;

	localparam int FIELD_W = 32;
	localparam int DIGIT_W = 4;
	localparam int NUM_FIELDS = 3;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LOWER_V = 8'h76;
	localparam logic [7:0] CH_UPPER_V = 8'h56;
	localparam logic [7:0] CH_DASH = 8'h2d;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_DOT = 8'h2e;

	typedef logic [FIELD_W-1:0] field_t;

	// byte classes produced by the front end
	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_DOT,
		CLS_DASH,
		CLS_PLUS,
		CLS_SKIP,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		cls_t               cls;
		logic [DIGIT_W-1:0] digit;
		logic               last;
		logic               func;
	} tok_t;

	// parser phase inside one string
	typedef enum logic [1:0] {
		PH_CORE,
		PH_DASH,
		PH_TAIL
	} phase_t;

endpackage

### rtl/vspc_in_if.sv
// vspc_in_if: byte channel into the version string parser
// depends on nothing
interface vspc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;
	logic       func;

	modport source (output valid, output ch, output last, output func, input ready);
	modport sink (input valid, input ch, input last, input func, output ready);
endinterface

### rtl/vspc_out_if.sv
// vspc_out_if: result channel out of the version string parser
// depends on nothing
interface vspc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] major_num;
	logic [31:0] minor_num;
	logic [31:0] patch_num;
	logic        is_prerelease;
	logic        valid_res;
	logic        newer;

	modport source (output valid, output major_num, output minor_num, output patch_num,
		output is_prerelease, output valid_res, output newer, input ready);
	modport sink (input valid, input major_num, input minor_num, input patch_num,
		input is_prerelease, input valid_res, input newer, output ready);
endinterface

### rtl/version_string_parse_compare_top.sv
// version_string_parse_compare_top: top level of the version string parser
// depends on vspc_pkg, vspc_in_if, vspc_out_if, vspc_front, vspc_fifo, vspc_back
//
// version text enters one byte per word on req, the word with last set closing
// the string; func on that last word picks store-as-latest (0) or compare (1).
// the block takes one byte every cycle for as long as results are drained; the
// back end updates its parse state once per cycle, which sets that rate. the
// result word for a string reaches rsp through the queue write, the parse
// update with result capture, and the compare into the output register. a
// leading v or V is dropped, the first dash or plus ends
// the numeric core, and a byte right after the dash other than plus marks a
// prerelease. invalid strings return all-zero fields with valid_res low. newer
// is set only for a compare when both the stored latest and the current string
// are valid and the latest orders higher. the queue between front and back
// holds QDEPTH words and absorbs a stall on either side; a string's last byte
// waits in it until the result stage is free.
module version_string_parse_compare_top #(
	parameter int QDEPTH = 4
) (
	input logic        clk,
	input logic        arst_n,
	vspc_in_if.sink    req,
	vspc_out_if.source rsp
);
	import vspc_pkg::*;

	// queue handshake
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	tok_t wr_tok;
	tok_t rd_tok;

	// byte classification and prefix drop
	vspc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_tok  (wr_tok)
	);

	// decouples the input side from result stalls
	vspc_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_tok (wr_tok),
		.pop    (q_pop),
		.rd_tok (rd_tok),
		.full   (q_full),
		.empty  (q_empty)
	);

	// parse, store latest, compare, output register
	vspc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_tok   (rd_tok),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

`ifndef SYNTHESIS
	// never write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue write while full");

	// never read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	// newer needs a valid current version
	a_newer_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.newer |-> rsp.valid_res)
		else $error("newer set on invalid string");

	// invalid strings carry zero fields
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.valid_res |-> rsp.major_num == '0 && rsp.minor_num == '0
			&& rsp.patch_num == '0 && !rsp.is_prerelease)
		else $error("invalid string with nonzero fields");
`endif

endmodule

### rtl/vspc_front.sv
// vspc_front: accepts text bytes and classifies them into tokens for the queue
// depends on vspc_pkg and vspc_in_if
module vspc_front (
	input  logic           clk,
	input  logic           arst_n,
	vspc_in_if.sink        req,
	input  logic           q_full,
	output logic           q_push,
	output vspc_pkg::tok_t q_tok
);
	import vspc_pkg::*;

	logic first_q;
	cls_t cls;

	assign req.ready = !q_full;
	assign q_push = req.valid && !q_full;

	always_comb begin
		if (req.ch >= CH_ZERO && req.ch <= CH_NINE) begin
			cls = CLS_DIGIT;
		end else if (req.ch == CH_DOT) begin
			cls = CLS_DOT;
		end else if (req.ch == CH_DASH) begin
			cls = CLS_DASH;
		end else if (req.ch == CH_PLUS) begin
			cls = CLS_PLUS;
		end else if (first_q && (req.ch == CH_LOWER_V || req.ch == CH_UPPER_V)) begin
			cls = CLS_SKIP;
		end else begin
			cls = CLS_OTHER;
		end
	end

	always_comb begin
		q_tok.cls = cls;
		q_tok.digit = req.ch[DIGIT_W-1:0];
		q_tok.last = req.last;
		q_tok.func = req.func;
	end

	// first byte of a string follows a last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (q_push) begin
			first_q <= req.last;
		end
	end

endmodule

### rtl/vspc_fifo.sv
// vspc_fifo: small token queue between the front end and the back end
// depends on vspc_pkg
module vspc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vspc_pkg::tok_t wr_tok,
	input  logic           pop,
	output vspc_pkg::tok_t rd_tok,
	output logic           full,
	output logic           empty
);
	import vspc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	tok_t          entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign rd_tok = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/vspc_back.sv
// vspc_back: per-string parse state, result stage, compare with stored latest
// depends on vspc_pkg and vspc_out_if
module vspc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  vspc_pkg::tok_t q_tok,
	output logic           q_pop,
	vspc_out_if.source     rsp
);
	import vspc_pkg::*;

	phase_t phase_q, phase_d;
	field_t acc_q [NUM_FIELDS];
	field_t acc_d [NUM_FIELDS];
	logic [1:0] idx_q, idx_d, idx_sel;
	logic seg_q, seg_d;
	logic err_q, err_d;
	logic pre_q, pre_d;
	logic in_core, in_dash;
	logic str_end, str_ok;

	field_t f_s1 [NUM_FIELDS];
	logic   pre_s1, ok_s1, func_s1, vld_s1;

	field_t lat_q [NUM_FIELDS];
	logic   lat_pre_q, lat_ok_q;

	logic   out_load, s1_free, gt, newer_d;

	field_t maj_s2, min_s2, pat_s2;
	logic   pre_s2, ok_s2, newer_s2, vld_s2;

	assign out_load = vld_s1 && (!vld_s2 || rsp.ready);
	assign s1_free = !vld_s1 || out_load;
	// a last token must find the result stage free
	assign q_pop = !q_empty && (!q_tok.last || s1_free);
	assign str_end = q_pop && q_tok.last;

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_CORE: begin
				if (q_pop && q_tok.cls == CLS_DASH) begin
					phase_d = PH_DASH;
				end else if (q_pop && q_tok.cls == CLS_PLUS) begin
					phase_d = PH_TAIL;
				end
			end
			PH_DASH: begin
				if (q_pop) begin
					phase_d = PH_TAIL;
				end
			end
			PH_TAIL: phase_d = PH_TAIL;
			default: phase_d = PH_CORE;
		endcase
		if (str_end) begin
			phase_d = PH_CORE;
		end
	end

	// phase decode
	always_comb begin
		in_core = 1'b0;
		in_dash = 1'b0;
		case (phase_q)
			PH_CORE: in_core = q_pop;
			PH_DASH: in_dash = q_pop;
			PH_TAIL: ;
			default: ;
		endcase
	end

	assign idx_sel = (idx_q > 2'd2) ? 2'd2 : idx_q;

	always_comb begin
		idx_d = idx_q;
		seg_d = seg_q;
		err_d = err_q;
		pre_d = pre_q;
		for (int i = 0; i < NUM_FIELDS; i++) begin
			acc_d[i] = acc_q[i];
		end
		if (in_core) begin
			case (q_tok.cls)
				CLS_DIGIT: begin
					// times ten as two shifts and an add
					acc_d[idx_sel] = (acc_q[idx_sel] << 3) + (acc_q[idx_sel] << 1)
						+ FIELD_W'(q_tok.digit);
					seg_d = 1'b1;
				end
				CLS_DOT: begin
					if (idx_q >= 2'd2 || !seg_q) begin
						err_d = 1'b1;
					end else begin
						idx_d = idx_q + 2'd1;
					end
					seg_d = 1'b0;
				end
				CLS_DASH: ;
				CLS_PLUS: ;
				CLS_SKIP: ;
				CLS_OTHER: err_d = 1'b1;
				default: err_d = 1'b1;
			endcase
		end
		if (in_dash) begin
			pre_d = (q_tok.cls != CLS_PLUS);
		end
	end

	assign str_ok = !err_d && idx_d == 2'd2 && seg_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CORE;
			idx_q <= '0;
			seg_q <= 1'b0;
			err_q <= 1'b0;
			pre_q <= 1'b0;
			for (int i = 0; i < NUM_FIELDS; i++) begin
				acc_q[i] <= '0;
			end
		end else begin
			phase_q <= phase_d;
			if (str_end) begin
				idx_q <= '0;
				seg_q <= 1'b0;
				err_q <= 1'b0;
				pre_q <= 1'b0;
				for (int i = 0; i < NUM_FIELDS; i++) begin
					acc_q[i] <= '0;
				end
			end else begin
				idx_q <= idx_d;
				seg_q <= seg_d;
				err_q <= err_d;
				pre_q <= pre_d;
				for (int i = 0; i < NUM_FIELDS; i++) begin
					acc_q[i] <= acc_d[i];
				end
			end
		end
	end

	// result stage: fields are zeroed for an invalid string
	always_ff @(posedge clk) begin
		if (str_end) begin
			for (int i = 0; i < NUM_FIELDS; i++) begin
				f_s1[i] <= str_ok ? acc_d[i] : '0;
			end
			pre_s1 <= str_ok && pre_d;
			ok_s1 <= str_ok;
			func_s1 <= q_tok.func;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (str_end) begin
			vld_s1 <= 1'b1;
		end else if (out_load) begin
			vld_s1 <= 1'b0;
		end
	end

	// latest greater than current: major, minor, patch, then release over prerelease
	always_comb begin
		if (lat_q[0] != f_s1[0]) begin
			gt = lat_q[0] > f_s1[0];
		end else if (lat_q[1] != f_s1[1]) begin
			gt = lat_q[1] > f_s1[1];
		end else if (lat_q[2] != f_s1[2]) begin
			gt = lat_q[2] > f_s1[2];
		end else begin
			gt = !lat_pre_q && pre_s1;
		end
	end

	assign newer_d = func_s1 && ok_s1 && lat_ok_q && gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_pre_q <= 1'b0;
			lat_ok_q <= 1'b0;
			for (int i = 0; i < NUM_FIELDS; i++) begin
				lat_q[i] <= '0;
			end
		end else if (out_load && !func_s1) begin
			lat_pre_q <= pre_s1;
			lat_ok_q <= ok_s1;
			for (int i = 0; i < NUM_FIELDS; i++) begin
				lat_q[i] <= f_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			maj_s2 <= f_s1[0];
			min_s2 <= f_s1[1];
			pat_s2 <= f_s1[2];
			pre_s2 <= pre_s1;
			ok_s2 <= ok_s1;
			newer_s2 <= newer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_load) begin
			vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	assign rsp.valid = vld_s2;
	assign rsp.major_num = maj_s2;
	assign rsp.minor_num = min_s2;
	assign rsp.patch_num = pat_s2;
	assign rsp.is_prerelease = pre_s2;
	assign rsp.valid_res = ok_s2;
	assign rsp.newer = newer_s2;

endmodule
